// ===== hdl/fspd_pkg.sv =====
// Package with the types and constants shared by the status packet deframer files.
`timescale 1ns / 1ps
`default_nettype none
package fspd_pkg;

   localparam logic [7:0] SwHdr = 8'hAA;
   localparam logic [7:0] SwEnd = 8'h55;
   localparam logic [7:0] VtHdr = 8'hCC;
   localparam logic [7:0] VtEnd = 8'h66;
   localparam logic [3:0] SwLen = 4'd4;
   localparam logic [3:0] VtLen = 4'd7;
   localparam logic [3:0] RlLen = 4'd5;
   localparam logic [15:0] BatMax = 16'd5000;
   localparam logic [7:0] PctMax = 8'd100;
   localparam logic [3:0] RelayMaskReset = 4'h2;
   localparam int FrameDepth = 7;
   localparam logic [2:0] LastIndex = 3'd7;

   localparam logic [7:0] RelayHeadReset = 8'd187;
   localparam logic [7:0] RelayTailReset = 8'd68;

   typedef enum logic {
      REG_RELAY_HEAD = 1'b0,
      REG_RELAY_TAIL = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      PS_IDLE    = 3'd0,
      PS_SW_DATA = 3'd1,
      PS_SW_END  = 3'd2,
      PS_VT_DATA = 3'd3,
      PS_VT_END  = 3'd4,
      PS_RL_DATA = 3'd5,
      PS_RL_END  = 3'd6
   } parse_state_type;

   typedef enum logic [2:0] {
      EV_SW_OK   = 3'd0,
      EV_VT_OK   = 3'd1,
      EV_RL_OK   = 3'd2,
      EV_VT_REJ  = 3'd3,
      EV_FRAMING = 3'd4
   } event_kind_type;

   typedef struct packed {
      logic [31:0] switch_bits;
      logic [12:0] battery_mv;
      logic        power_status;
      logic        pwr_fail;
      logic        batt_low;
      logic [6:0]  battery_percent;
      logic [3:0]  relay_mask;
      logic        relay_locked;
      logic [31:0] switch_frame_count;
      logic [31:0] relay_sequence;
   } snap_type;

   typedef struct packed {
      logic           fire;
      event_kind_type kind;
   } evt_type;

   localparam snap_type SnapReset = '{
      switch_bits:        32'd0,
      battery_mv:         13'd0,
      power_status:       1'b0,
      pwr_fail:           1'b0,
      batt_low:           1'b0,
      battery_percent:    7'd0,
      relay_mask:         RelayMaskReset,
      relay_locked:       1'b0,
      switch_frame_count: 32'd0,
      relay_sequence:     32'd0
   };

endpackage
`default_nettype wire

// ===== hdl/fspd_if.sv =====
// Valid/ready channel interfaces for received bytes and deframer results.
`timescale 1ns / 1ps
`default_nettype none
interface fspd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface fspd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_kind;
   logic [31:0] switch_bits;
   logic [12:0] battery_mv;
   logic        power_status;
   logic        pwr_fail;
   logic        batt_low;
   logic [6:0]  battery_percent;
   logic [3:0]  relay_mask;
   logic        relay_locked;
   logic [31:0] switch_frame_count;
   logic [31:0] relay_sequence;
   modport source (output valid, output event_kind, output switch_bits, output battery_mv,
                   output power_status, output pwr_fail, output batt_low,
                   output battery_percent, output relay_mask, output relay_locked,
                   output switch_frame_count, output relay_sequence, input ready);
   modport sink (input valid, input event_kind, input switch_bits, input battery_mv,
                 input power_status, input pwr_fail, input batt_low,
                 input battery_percent, input relay_mask, input relay_locked,
                 input switch_frame_count, input relay_sequence, output ready);
endinterface
`default_nettype wire

// ===== hdl/framed_status_packet_deframer.sv =====
// Top level of the status packet deframer: handshakes, register port and result register.
// Data path: an accepted byte waits in the input register, then is processed into the
// result register, if it ends a frame, once that register is free; rsp valid then rises.
// Throughput: one byte per cycle while the result register is not stalled.
// Reset (synchronous): parser idle, snapshot cleared with relay 2 on, counters zero,
// relay header 187 and relay end byte 68.
`timescale 1ns / 1ps
`default_nettype none
module framed_status_packet_deframer #(
   parameter int SWITCH_COUNT = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   fspd_req_if.sink         req_if,
   fspd_rsp_if.source       rsp_if,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import fspd_pkg::*;

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   event_kind_type     rsp_kind_ff;
   snap_type           rsp_snap_ff;
   logic [7:0]         relay_head_ff, relay_tail_ff;
   logic               out_free, advance, req_take, csr_write;
   reg_index_type      csr_index;
   evt_type            evt;
   snap_type           snap_next;

   fspd_core #(.SWITCH_COUNT(SWITCH_COUNT)) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .rx_byte    (in_byte_ff),
      .relay_head (relay_head_ff),
      .relay_tail (relay_tail_ff),
      .evt        (evt),
      .snap_next  (snap_next)
   );

   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign advance      = in_valid_ff && out_free;
   assign req_if.ready = !in_valid_ff || advance;
   assign req_take     = req_if.valid && req_if.ready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = (advance && evt.fire) ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   assign csr_index  = reg_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_index)
         REG_RELAY_HEAD: csr_prdata = {24'd0, relay_head_ff};
         REG_RELAY_TAIL: csr_prdata = {24'd0, relay_tail_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         relay_head_ff <= RelayHeadReset;
         relay_tail_ff <= RelayTailReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write && csr_index == REG_RELAY_HEAD) begin
            relay_head_ff <= csr_pwdata[7:0];
         end
         if (csr_write && csr_index == REG_RELAY_TAIL) begin
            relay_tail_ff <= csr_pwdata[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_if.rx_byte;
      end
      if (advance && evt.fire) begin
         rsp_kind_ff <= evt.kind;
         rsp_snap_ff <= snap_next;
      end
   end

   assign rsp_if.valid              = rsp_valid_ff;
   assign rsp_if.event_kind         = rsp_kind_ff;
   assign rsp_if.switch_bits        = rsp_snap_ff.switch_bits;
   assign rsp_if.battery_mv         = rsp_snap_ff.battery_mv;
   assign rsp_if.power_status       = rsp_snap_ff.power_status;
   assign rsp_if.pwr_fail           = rsp_snap_ff.pwr_fail;
   assign rsp_if.batt_low           = rsp_snap_ff.batt_low;
   assign rsp_if.battery_percent    = rsp_snap_ff.battery_percent;
   assign rsp_if.relay_mask         = rsp_snap_ff.relay_mask;
   assign rsp_if.relay_locked       = rsp_snap_ff.relay_locked;
   assign rsp_if.switch_frame_count = rsp_snap_ff.switch_frame_count;
   assign rsp_if.relay_sequence     = rsp_snap_ff.relay_sequence;

   a_held_byte_stable : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("waiting input byte was lost or changed");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      advance && evt.fire && rsp_valid_ff |-> rsp_if.ready)
      else $error("result register overwritten before its transaction completed");

   a_fire_sets_valid : assert property (@(posedge clock) disable iff (reset)
      advance && evt.fire |=> rsp_valid_ff)
      else $error("end byte processed without presenting a result");

endmodule
`default_nettype wire

// ===== hdl/fspd_core.sv =====
// Frame parser state machine, frame byte store and held status snapshot.
`timescale 1ns / 1ps
`default_nettype none
module fspd_core #(
   parameter int SWITCH_COUNT = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [7:0]        rx_byte,
   input  wire logic [7:0]        relay_head,
   input  wire logic [7:0]        relay_tail,
   output fspd_pkg::evt_type      evt,
   output fspd_pkg::snap_type     snap_next
);
   import fspd_pkg::*;

   localparam logic [31:0] SwMask = 32'hFFFF_FFFF >> (32 - SWITCH_COUNT);

   parse_state_type state_ff, state_in;
   logic [2:0]      idx_ff, idx_in;
   logic [3:0]      idx_sum;
   logic [7:0]      frame_ff [FrameDepth];
   snap_type        snap_ff, snap_in;
   logic            wr_en;
   logic            sw_commit, vt_commit, rl_commit;
   logic            vt_ok;
   logic [15:0]     bat_word, pwr_word;

   assign idx_sum  = {1'b0, idx_ff} + 4'd1;
   assign bat_word = {frame_ff[0], frame_ff[1]};
   assign pwr_word = {frame_ff[2], frame_ff[3]};
   assign vt_ok    = (bat_word <= BatMax) && (frame_ff[6] <= PctMax)
                     && (frame_ff[4] <= 8'd1) && (frame_ff[5] <= 8'd1)
                     && (pwr_word <= 16'd1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         PS_IDLE: begin
            idx_in = 3'd0;
            if (rx_byte == SwHdr) begin
               state_in = PS_SW_DATA;
            end else if (rx_byte == VtHdr) begin
               state_in = PS_VT_DATA;
            end else if (rx_byte == relay_head) begin
               state_in = PS_RL_DATA;
            end
         end
         PS_SW_DATA: begin
            idx_in = idx_sum[2:0];
            if (idx_sum >= SwLen) begin
               state_in = PS_SW_END;
            end
         end
         PS_VT_DATA: begin
            idx_in = idx_sum[2:0];
            if (idx_sum >= VtLen) begin
               state_in = PS_VT_END;
            end
         end
         PS_RL_DATA: begin
            idx_in = idx_sum[2:0];
            if (idx_sum >= RlLen) begin
               state_in = PS_RL_END;
            end
         end
         default: begin
            state_in = PS_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      wr_en     = 1'b0;
      sw_commit = 1'b0;
      vt_commit = 1'b0;
      rl_commit = 1'b0;
      evt.fire  = 1'b0;
      evt.kind  = EV_FRAMING;
      case (state_ff)
         PS_SW_DATA, PS_VT_DATA, PS_RL_DATA: begin
            wr_en = (idx_ff != LastIndex);
         end
         PS_SW_END: begin
            evt.fire = 1'b1;
            if (rx_byte == SwEnd) begin
               sw_commit = 1'b1;
               evt.kind  = EV_SW_OK;
            end
         end
         PS_VT_END: begin
            evt.fire = 1'b1;
            if (rx_byte == VtEnd) begin
               vt_commit = vt_ok;
               evt.kind  = vt_ok ? EV_VT_OK : EV_VT_REJ;
            end
         end
         PS_RL_END: begin
            evt.fire = 1'b1;
            if (rx_byte == relay_tail) begin
               rl_commit = 1'b1;
               evt.kind  = EV_RL_OK;
            end
         end
         default: begin
            evt.fire = 1'b0;
         end
      endcase
   end

   always_comb begin
      snap_in = snap_ff;
      if (sw_commit) begin
         snap_in.switch_bits = {frame_ff[3], frame_ff[2], frame_ff[1], frame_ff[0]} & SwMask;
         snap_in.switch_frame_count = snap_ff.switch_frame_count + 32'd1;
      end
      if (vt_commit) begin
         snap_in.battery_mv      = bat_word[12:0];
         snap_in.power_status    = pwr_word[0];
         snap_in.pwr_fail        = frame_ff[4][0];
         snap_in.batt_low        = frame_ff[5][0];
         snap_in.battery_percent = frame_ff[6][6:0];
      end
      if (rl_commit) begin
         snap_in.relay_mask = {frame_ff[3] != 8'd0, frame_ff[2] != 8'd0,
                               frame_ff[1] != 8'd0, frame_ff[0] != 8'd0};
         snap_in.relay_locked   = (frame_ff[4] != 8'd0);
         snap_in.relay_sequence = snap_ff.relay_sequence + 32'd1;
      end
   end

   assign snap_next = snap_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PS_IDLE;
         idx_ff   <= 3'd0;
         snap_ff  <= SnapReset;
      end else if (step) begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         snap_ff  <= snap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && wr_en) begin
         frame_ff[idx_ff] <= rx_byte;
      end
   end

   a_fire_returns_idle : assert property (@(posedge clock) disable iff (reset)
      step && evt.fire |=> state_ff == PS_IDLE)
      else $error("state did not return to idle after an end byte");

   a_switch_count_bumps : assert property (@(posedge clock) disable iff (reset)
      step && state_ff == PS_SW_END && rx_byte == SwEnd
      |=> snap_ff.switch_frame_count == $past(snap_ff.switch_frame_count) + 32'd1)
      else $error("switch frame count did not advance on a good switch frame");

   a_index_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == PS_SW_DATA || state_ff == PS_VT_DATA || state_ff == PS_RL_DATA)
      |-> idx_ff != LastIndex)
      else $error("frame byte index left the store");

   a_reject_holds_voltage : assert property (@(posedge clock) disable iff (reset)
      step && evt.fire && evt.kind == EV_VT_REJ
      |=> $stable(snap_ff.battery_mv) && $stable(snap_ff.battery_percent))
      else $error("rejected voltage frame altered the held values");

endmodule
`default_nettype wire

// ===== tb/sv/tb_framed_status_packet_deframer.sv =====
// Self-checking testbench for the framed status packet deframer, with its own predictor.
`timescale 1ns / 1ps
module tb_framed_status_packet_deframer;
   import fspd_pkg::*;

   localparam int SwitchCount = 32;
   localparam int SettleCycles = 6;
   localparam int HoldCycles = 400;
   localparam int IdleLimit = 3000;

   typedef struct packed {
      event_kind_type kind;
      snap_type       snap;
   } report_type;

   typedef enum int {
      FLAW_NONE,
      FLAW_BATTERY,
      FLAW_PERCENT,
      FLAW_FAIL_FLAG,
      FLAW_LOW_FLAG,
      FLAW_POWER
   } volt_flaw_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   fspd_req_if req_ch ();
   fspd_rsp_if rsp_ch ();

   framed_status_packet_deframer #(
      .SWITCH_COUNT(SwitchCount)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Predictor state.
   parse_state_type pstate;
   logic [2:0]      frame_idx;
   logic [7:0]      frame [FrameDepth];
   snap_type        held;
   logic [7:0]      relay_head;
   logic [7:0]      relay_tail;

   report_type expected_reports [$];
   logic [7:0] byte_q [$];

   int  errors;
   int  bytes_taken;
   int  settings_used;
   int  kind_seen [5];
   int  results_seen;
   int  burst_left;
   int  gap_left;
   int  hold_left;
   bit  hold_done;
   bit  calm;
   int  idle_cycles;
   logic [15:0] stall_pattern;
   logic [3:0]  pattern_pos;

   always #5 clock = ~clock;

   function automatic void store_data(input logic [7:0] b, input logic [3:0] len,
                                      input parse_state_type nxt);
      frame[frame_idx] = b;
      frame_idx = frame_idx + 3'd1;
      if ({1'b0, frame_idx} >= len) pstate = nxt;
   endfunction

   function automatic void absorb_byte(input logic [7:0] b);
      report_type  res;
      logic [15:0] bat;
      logic [15:0] pwr;
      logic [31:0] sw;
      logic        fire;
      fire = 1'b0;
      res.kind = EV_FRAMING;
      case (pstate)
         PS_IDLE: begin
            frame_idx = 3'd0;
            if (b == SwHdr) pstate = PS_SW_DATA;
            else if (b == VtHdr) pstate = PS_VT_DATA;
            else if (b == relay_head) pstate = PS_RL_DATA;
         end
         PS_SW_DATA: store_data(b, SwLen, PS_SW_END);
         PS_VT_DATA: store_data(b, VtLen, PS_VT_END);
         PS_RL_DATA: store_data(b, RlLen, PS_RL_END);
         PS_SW_END: begin
            fire = 1'b1;
            if (b == SwEnd) begin
               sw = '0;
               for (int i = 0; i < SwitchCount && i < 32; i++) sw[i] = frame[i / 8][i % 8];
               held.switch_bits = sw;
               held.switch_frame_count = held.switch_frame_count + 32'd1;
               res.kind = EV_SW_OK;
            end
         end
         PS_VT_END: begin
            fire = 1'b1;
            if (b == VtEnd) begin
               bat = {frame[0], frame[1]};
               pwr = {frame[2], frame[3]};
               if (bat > BatMax || frame[6] > PctMax || frame[4] > 8'd1 || frame[5] > 8'd1
                   || pwr > 16'd1) begin
                  res.kind = EV_VT_REJ;
               end else begin
                  held.battery_mv = bat[12:0];
                  held.power_status = pwr[0];
                  held.pwr_fail = frame[4][0];
                  held.batt_low = frame[5][0];
                  held.battery_percent = frame[6][6:0];
                  res.kind = EV_VT_OK;
               end
            end
         end
         PS_RL_END: begin
            fire = 1'b1;
            if (b == relay_tail) begin
               held.relay_mask = {frame[3] != 8'd0, frame[2] != 8'd0,
                                  frame[1] != 8'd0, frame[0] != 8'd0};
               held.relay_locked = frame[4] != 8'd0;
               held.relay_sequence = held.relay_sequence + 32'd1;
               res.kind = EV_RL_OK;
            end
         end
         default: pstate = PS_IDLE;
      endcase
      if (fire) begin
         pstate = PS_IDLE;
         res.snap = held;
         expected_reports.push_back(res);
      end
   endfunction

   function automatic logic [7:0] other_than(input logic [7:0] v);
      logic [7:0] r;
      do r = 8'($urandom_range(0, 255)); while (r == v);
      return r;
   endfunction

   task automatic push_switch(input bit good_end);
      byte_q.push_back(SwHdr);
      repeat (SwLen) byte_q.push_back(8'($urandom_range(0, 255)));
      byte_q.push_back(good_end ? SwEnd : other_than(SwEnd));
   endtask

   task automatic push_voltage(input volt_flaw_type flaw, input bit good_end);
      logic [15:0] bat;
      logic [15:0] pwr;
      logic [7:0]  pf;
      logic [7:0]  lb;
      logic [7:0]  pct;
      bat = 16'($urandom_range(0, BatMax));
      pwr = 16'($urandom_range(0, 1));
      pf = 8'($urandom_range(0, 1));
      lb = 8'($urandom_range(0, 1));
      pct = 8'($urandom_range(0, PctMax));
      case (flaw)
         FLAW_BATTERY:   bat = 16'($urandom_range(BatMax + 1, 16'hFFFF));
         FLAW_PERCENT:   pct = 8'($urandom_range(PctMax + 1, 255));
         FLAW_FAIL_FLAG: pf = 8'($urandom_range(2, 255));
         FLAW_LOW_FLAG:  lb = 8'($urandom_range(2, 255));
         FLAW_POWER:     pwr = 16'($urandom_range(2, 16'hFFFF));
         default: ;
      endcase
      byte_q.push_back(VtHdr);
      byte_q.push_back(bat[15:8]);
      byte_q.push_back(bat[7:0]);
      byte_q.push_back(pwr[15:8]);
      byte_q.push_back(pwr[7:0]);
      byte_q.push_back(pf);
      byte_q.push_back(lb);
      byte_q.push_back(pct);
      byte_q.push_back(good_end ? VtEnd : other_than(VtEnd));
   endtask

   task automatic push_relay(input bit good_end);
      byte_q.push_back(relay_head);
      repeat (RlLen) byte_q.push_back($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 255)));
      byte_q.push_back(good_end ? relay_tail : other_than(relay_tail));
   endtask

   task automatic push_traffic(input int count);
      int pick;
      bit good_end;
      while (byte_q.size() < count) begin
         pick = $urandom_range(0, 9);
         good_end = $urandom_range(0, 7) != 0;
         if (pick < 3) begin
            push_switch(good_end);
         end else if (pick < 6) begin
            if ($urandom_range(0, 3) == 0)
               push_voltage(volt_flaw_type'($urandom_range(FLAW_BATTERY, FLAW_POWER)), good_end);
            else
               push_voltage(FLAW_NONE, good_end);
         end else if (pick < 9) begin
            push_relay(good_end);
         end else begin
            repeat ($urandom_range(1, 4)) byte_q.push_back(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Waits until every byte is taken and every result is back, then lets the pipeline settle.
   task automatic drain();
      do @(negedge clock);
      while (byte_q.size() != 0 || req_ch.valid || expected_reports.size() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [7:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {24'($urandom()), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_RELAY_HEAD) relay_head = value;
      else relay_tail = value;
      @(posedge clock);
   endtask

   task automatic new_setting(input logic [7:0] hdr, input logic [7:0] endb, input int count,
                              input bit no_idle);
      drain();
      csr_write(REG_RELAY_HEAD, hdr);
      csr_write(REG_RELAY_TAIL, endb);
      settings_used++;
      @(negedge clock);
      calm = no_idle;
      push_traffic(count);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // Byte driver: bursts of random length separated by random gaps, with no gaps in calm mode.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) begin
            absorb_byte(req_ch.rx_byte);
            bytes_taken++;
         end
         if (gap_left > 0 && !calm) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (byte_q.size() > 0) begin
            req_ch.valid <= 1'b1;
            req_ch.rx_byte <= byte_q.pop_front();
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Result monitor with its own stall pattern and one long hold-off.
   always @(posedge clock) begin
      report_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual kind %0d", $time,
                        rsp_ch.event_kind);
               errors++;
            end else begin
               want = expected_reports.pop_front();
               if (want.kind <= EV_FRAMING) kind_seen[want.kind]++;
               compare_field("event_kind", 32'(want.kind), 32'(rsp_ch.event_kind));
               compare_field("switch_bits", want.snap.switch_bits, rsp_ch.switch_bits);
               compare_field("battery_mv", 32'(want.snap.battery_mv), 32'(rsp_ch.battery_mv));
               compare_field("power_status", 32'(want.snap.power_status),
                             32'(rsp_ch.power_status));
               compare_field("pwr_fail", 32'(want.snap.pwr_fail), 32'(rsp_ch.pwr_fail));
               compare_field("batt_low", 32'(want.snap.batt_low), 32'(rsp_ch.batt_low));
               compare_field("battery_percent", 32'(want.snap.battery_percent),
                             32'(rsp_ch.battery_percent));
               compare_field("relay_mask", 32'(want.snap.relay_mask), 32'(rsp_ch.relay_mask));
               compare_field("relay_locked", 32'(want.snap.relay_locked),
                             32'(rsp_ch.relay_locked));
               compare_field("switch_frame_count", want.snap.switch_frame_count,
                             rsp_ch.switch_frame_count);
               compare_field("relay_sequence", want.snap.relay_sequence,
                             rsp_ch.relay_sequence);
            end
            if (results_seen == 15 && !hold_done) begin
               hold_done = 1'b1;
               hold_left = HoldCycles;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (calm) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= stall_pattern[pattern_pos];
            pattern_pos = pattern_pos + 4'd1;
            if (pattern_pos == 4'd0) begin
               case ($urandom_range(0, 3))
                  0: stall_pattern = 16'hFFFF;
                  1: stall_pattern = 16'($urandom());
                  default: stall_pattern = 16'($urandom() | $urandom());
               endcase
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("%0t: no transaction for %0d cycles", $time, IdleLimit);
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.rx_byte = '0;
      rsp_ch.ready = 1'b0;
      pstate = PS_IDLE;
      frame_idx = 3'd0;
      foreach (frame[i]) frame[i] = 8'd0;
      held = SnapReset;
      relay_head = RelayHeadReset;
      relay_tail = RelayTailReset;
      errors = 0;
      bytes_taken = 0;
      settings_used = 1;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      results_seen = 0;
      burst_left = 0;
      gap_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      calm = 1'b0;
      idle_cycles = 0;
      stall_pattern = 16'hF7DE;
      pattern_pos = 4'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed frames: all switches on, a bad switch end byte that looks like a header,
      // a voltage frame at every plausible limit, and a relay frame with mixed bytes.
      byte_q = '{SwHdr, 8'hFF, 8'hFF, 8'hFF, 8'hFF, SwEnd,
                 SwHdr, 8'h00, 8'h00, 8'h00, 8'h00, SwHdr,
                 VtHdr, 8'h13, 8'h88, 8'h00, 8'h01, 8'h01, 8'h01, 8'h64, VtEnd,
                 RelayHeadReset, 8'h01, 8'h00, 8'hFF, 8'h00, 8'h80, RelayTailReset};
      push_traffic(330);

      new_setting(SwHdr, 8'h00, 150, 1'b0);
      new_setting(VtHdr, 8'hFF, 150, 1'b0);
      new_setting(8'h00, SwEnd, 150, 1'b0);
      new_setting(8'hFF, 8'($urandom_range(1, 254)), 150, 1'b1);

      drain();
      if (expected_reports.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_reports.size());
         errors++;
      end
      $display("Covered %0d received bytes over %0d relay byte settings, %0d results checked.",
               bytes_taken, settings_used, results_seen);
      $display("Results: switch %0d, voltage %0d, relay %0d, rejected %0d, framing %0d.",
               kind_seen[EV_SW_OK], kind_seen[EV_VT_OK], kind_seen[EV_RL_OK],
               kind_seen[EV_VT_REJ], kind_seen[EV_FRAMING]);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
